### src/sgdm_pkg.sv
// ----------------------------------------------------------------------------
// sgdm_pkg: shared constants, types and fixed-point helpers
// Widths, register codes, velocity store ports and Q16.16 arithmetic.
// ----------------------------------------------------------------------------
package sgdm_pkg;

  // Store geometry and number format
  localparam int STORE_DEPTH = 4096;
  localparam int FRAC_BITS   = 16;

  localparam int IDX_W   = 12;
  localparam int DATA_W  = 32;
  localparam int COEF_W  = 18;
  localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Coefficient times value product, rounded sum headroom
  localparam int PROD_W  = COEF_W + 1 + DATA_W;
  localparam int SUM_W   = PROD_W + 2;

  // Index reduction by reciprocal: quotient estimate is exact or one low
  localparam int RECIP_SH = 24;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / STORE_DEPTH);
  localparam int QPROD_W  = IDX_W + RECIP_W;
  localparam int MOD_W    = IDX_W + $clog2(STORE_DEPTH + 1) + 1;

  // Configuration register codes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_DECAY  = 2'd2;

  localparam logic [COEF_W-1:0] LR_RESET = COEF_W'(655);

  // Stream payload widths
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 64;

  localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) << (DATA_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) << (DATA_W - 1));

  typedef struct packed {
    logic                     en;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] data;
  } vel_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } vel_rd_t;

  function automatic logic signed [PROD_W-1:0] coef_mul(logic [COEF_W-1:0] c,
                                                        logic signed [DATA_W-1:0] v);
    return $signed({1'b0, c}) * v;
  endfunction

  // floor((p + half) / 2^FRAC_BITS)
  function automatic logic signed [SUM_W-1:0] round_scale(logic signed [PROD_W-1:0] p);
    logic signed [SUM_W-1:0] t;
    t = SUM_W'(p) + HALF;
    return t >>> FRAC_BITS;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(logic signed [SUM_W-1:0] s);
    logic signed [DATA_W-1:0] r;
    if (s > SAT_HI) begin
      r = SAT_HI[DATA_W-1:0];
    end else if (s < SAT_LO) begin
      r = SAT_LO[DATA_W-1:0];
    end else begin
      r = s[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] quot_est(logic [IDX_W-1:0] idx);
    logic [QPROD_W-1:0] p;
    p = QPROD_W'(idx) * QPROD_W'(RECIP);
    return p[RECIP_SH +: IDX_W];
  endfunction

  function automatic logic [ADDR_W-1:0] addr_rem(logic [IDX_W-1:0] idx,
                                                 logic [IDX_W-1:0] q);
    logic [MOD_W-1:0] r;
    r = MOD_W'(idx) - MOD_W'(q) * MOD_W'(STORE_DEPTH);
    if (r >= MOD_W'(STORE_DEPTH)) begin
      r = r - MOD_W'(STORE_DEPTH);
    end
    return ADDR_W'(r);
  endfunction

endpackage

### src/sgdm_vel_ram.sv
// ----------------------------------------------------------------------------
// sgdm_vel_ram: velocity store
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module sgdm_vel_ram
  import sgdm_pkg::*;
(
  input  logic                     clk_i,
  input  vel_wr_t                  wr_i,
  input  vel_rd_t                  rd_i,
  output logic signed [DATA_W-1:0] rd_data_o
);

  logic signed [DATA_W-1:0] mem [STORE_DEPTH];
  logic signed [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Hold the last read word until the next enabled read
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/sgd_momentum_weight_decay_update.sv
// ----------------------------------------------------------------------------
// sgd_momentum_weight_decay_update: element-wise SGD step, momentum, L2 decay
// Stages S1 to S7, then the output register; one beat per cycle when nothing stalls.
// Back-to-back momentum updates of the same index are held in S3 (velocity loop).
// After reset the velocity store is cleared entry by entry, input held off.
// ----------------------------------------------------------------------------
module sgd_momentum_weight_decay_update
  import sgdm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  // Configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_W-1:0]    cfg_wdata_i,

  // Input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [11:0] elem_index, [43:12] param_value, [75:44] grad_value, [79:76] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,

  // Output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [31:0] new_param, [63:32] decayed_grad
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  // --------------------------------------------------------------------------
  // Pipeline map
  //   S1  input register, weight decay product, index quotient estimate
  //   S2  decayed gradient (round, add, saturate), store address
  //   S3  issue velocity read as the beat moves on to S4
  //   S4  velocity (read data or forwarded write), momentum product
  //   S5  new velocity, write back, pick step operand
  //   S6  learning rate product
  //   S7  new parameter (round, subtract, saturate)
  //   out output register
  // Each stage advances when the next one is empty or advancing, so bubbles
  // collapse and input keeps flowing while a result waits at the output.
  // --------------------------------------------------------------------------

  // Configuration registers
  logic [COEF_W-1:0] lr_q, mom_q, wd_q;
  logic              mom_on;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q  <= LR_RESET;
      mom_q <= '0;
      wd_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LEARNING_RATE: lr_q  <= cfg_wdata_i;
        CFG_MOMENTUM:      mom_q <= cfg_wdata_i;
        CFG_WEIGHT_DECAY:  wd_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign mom_on = (mom_q != '0);

  // Clearing pass over the velocity store after reset
  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == ADDR_W'(STORE_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      end
    end
  end

  // Stage registers
  logic                     s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, s7_v_q;
  logic                     m_v_q;

  logic [IDX_W-1:0]         s1_idx_q, s2_idx_q, s2_quot_q;
  logic signed [DATA_W-1:0] s1_param_q, s1_grad_q, s2_param_q, s2_grad_q;
  logic signed [PROD_W-1:0] s2_pwd_q;

  logic [ADDR_W-1:0]        s3_addr_q, s4_addr_q, s5_addr_q;
  logic signed [DATA_W-1:0] s3_param_q, s3_g_q, s4_param_q, s4_g_q;
  logic                     s4_fwd_q;
  logic signed [DATA_W-1:0] s4_fwd_data_q;

  logic signed [DATA_W-1:0] s5_param_q, s5_g_q;
  logic signed [PROD_W-1:0] s5_pm_q;
  logic signed [DATA_W-1:0] s6_param_q, s6_g_q, s6_op_q;
  logic signed [DATA_W-1:0] s7_param_q, s7_g_q;
  logic signed [PROD_W-1:0] s7_plr_q;
  logic signed [DATA_W-1:0] m_np_q, m_g_q;

  // Stage logic
  logic signed [PROD_W-1:0] s1_pwd, s4_pm, s6_plr;
  logic [IDX_W-1:0]         s1_quot;
  logic signed [DATA_W-1:0] s2_g, s4_vel, s5_vnew, s7_np;
  logic [ADDR_W-1:0]        s2_addr;

  assign s1_pwd  = coef_mul(wd_q, s1_param_q);
  assign s1_quot = quot_est(s1_idx_q);
  assign s2_g    = sat32(SUM_W'(s2_grad_q) + round_scale(s2_pwd_q));
  assign s2_addr = addr_rem(s2_idx_q, s2_quot_q);

  // Velocity store interface
  vel_wr_t                  vel_wr;
  vel_rd_t                  vel_rd;
  logic signed [DATA_W-1:0] vel_rd_data;

  assign s4_vel  = s4_fwd_q ? s4_fwd_data_q : vel_rd_data;
  assign s4_pm   = coef_mul(mom_q, s4_vel);
  assign s5_vnew = sat32(round_scale(s5_pm_q) + SUM_W'(s5_g_q));
  assign s6_plr  = coef_mul(lr_q, s6_op_q);
  assign s7_np   = sat32(SUM_W'(s7_param_q) - round_scale(s7_plr_q));

  // Flow control, back to front
  logic out_free;
  logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;
  logic en1, en2, en3, en4, en5, en6, en7;
  logic s3_block, pipe_wr, in_acc;

  assign out_free = !m_v_q || m_axis_tready;
  assign adv7 = s7_v_q && out_free;
  assign en7  = !s7_v_q || adv7;
  assign adv6 = s6_v_q && en7;
  assign en6  = !s6_v_q || adv6;
  assign adv5 = s5_v_q && en6;
  assign en5  = !s5_v_q || adv5;
  assign adv4 = s4_v_q && en5;
  assign en4  = !s4_v_q || adv4;

  // Hold a beat in S3 while a beat ahead of it still has to write the same
  // entry after this read: the one in S4, or a stalled one in S5. A write
  // at the very edge of the read is caught by the forward register instead.
  assign s3_block = mom_on &&
                    ((s4_v_q && (s4_addr_q == s3_addr_q)) ||
                     (s5_v_q && !adv5 && (s5_addr_q == s3_addr_q)));

  assign adv3 = s3_v_q && en4 && !s3_block;
  assign en3  = !s3_v_q || adv3;
  assign adv2 = s2_v_q && en3;
  assign en2  = !s2_v_q || adv2;
  assign adv1 = s1_v_q && en2;
  assign en1  = !s1_v_q || adv1;

  assign s_axis_tready = en1 && !clr_busy_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Write back only with momentum on; otherwise the store keeps its contents
  assign pipe_wr = adv5 && mom_on;

  always_comb begin
    vel_wr.en   = clr_busy_q || pipe_wr;
    vel_wr.addr = clr_busy_q ? clr_cnt_q : s5_addr_q;
    vel_wr.data = clr_busy_q ? '0 : s5_vnew;
    vel_rd.en   = adv3;
    vel_rd.addr = s3_addr_q;
  end

  sgdm_vel_ram u_vel_ram (
    .clk_i     (clk_i),
    .wr_i      (vel_wr),
    .rd_i      (vel_rd),
    .rd_data_o (vel_rd_data)
  );

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
      m_v_q  <= 1'b0;
    end else begin
      s1_v_q <= in_acc || (s1_v_q && !adv1);
      s2_v_q <= adv1   || (s2_v_q && !adv2);
      s3_v_q <= adv2   || (s3_v_q && !adv3);
      s4_v_q <= adv3   || (s4_v_q && !adv4);
      s5_v_q <= adv4   || (s5_v_q && !adv5);
      s6_v_q <= adv5   || (s6_v_q && !adv6);
      s7_v_q <= adv6   || (s7_v_q && !adv7);
      m_v_q  <= adv7   || (m_v_q && !m_axis_tready);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_idx_q   <= s_axis_tdata[IDX_W-1:0];
      s1_param_q <= s_axis_tdata[IDX_W +: DATA_W];
      s1_grad_q  <= s_axis_tdata[IDX_W+DATA_W +: DATA_W];
    end
    if (adv1) begin
      s2_idx_q   <= s1_idx_q;
      s2_quot_q  <= s1_quot;
      s2_param_q <= s1_param_q;
      s2_grad_q  <= s1_grad_q;
      s2_pwd_q   <= s1_pwd;
    end
    if (adv2) begin
      s3_addr_q  <= s2_addr;
      s3_param_q <= s2_param_q;
      s3_g_q     <= s2_g;
    end
    if (adv3) begin
      s4_addr_q     <= s3_addr_q;
      s4_param_q    <= s3_param_q;
      s4_g_q        <= s3_g_q;
      s4_fwd_q      <= pipe_wr && (s5_addr_q == s3_addr_q);
      s4_fwd_data_q <= s5_vnew;
    end
    if (adv4) begin
      s5_addr_q  <= s4_addr_q;
      s5_param_q <= s4_param_q;
      s5_g_q     <= s4_g_q;
      s5_pm_q    <= s4_pm;
    end
    if (adv5) begin
      s6_param_q <= s5_param_q;
      s6_g_q     <= s5_g_q;
      s6_op_q    <= mom_on ? s5_vnew : s5_g_q;
    end
    if (adv6) begin
      s7_param_q <= s6_param_q;
      s7_g_q     <= s6_g_q;
      s7_plr_q   <= s6_plr;
    end
    if (adv7) begin
      m_np_q <= s7_np;
      m_g_q  <= s7_g_q;
    end
  end

  assign m_axis_tvalid = m_v_q;
  assign m_axis_tdata  = {m_g_q, m_np_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // No beat enters or reaches write back while the store is being cleared
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (!s_axis_tready && !s5_v_q))
    else $error("beat in flight during velocity clear");

  // The interlock keeps S4 and S5 on different entries with momentum on
  a_no_raw_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mom_on && s4_v_q && s5_v_q) |-> (s4_addr_q != s5_addr_q))
    else $error("S4 and S5 hold the same velocity entry");

  // A read that meets a write to the same entry must take the forwarded value
  a_fwd_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vel_rd.en && vel_wr.en && !clr_busy_q && (vel_rd.addr == vel_wr.addr))
      |=> s4_fwd_q)
    else $error("read during write not forwarded");

  // Forwarding only happens with momentum on
  a_fwd_mom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_v_q && s4_fwd_q) |-> mom_on)
    else $error("forward without momentum");

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the SGD momentum / weight decay update
// Streams parameter beats through the block under random back-pressure on both
// sides and checks every output beat against a hand-typed value or a Q16.16
// predictor that keeps its own coefficient copies and per-index velocity memory.
// ----------------------------------------------------------------------------
module tb_top;
  import sgdm_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 20;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 244;

  // Index 3 is not mapped to any register; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sd65536;
  localparam logic [COEF_W-1:0]        C_MAX = 18'h3FFFF;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_param;
    logic signed [DATA_W-1:0] decayed_grad;
  } update_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic [COEF_W-1:0]        reg_val;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] param;
    logic signed [DATA_W-1:0] grad;
    bit                       typed;
    update_t                  want;
  } step_row_t;

  // DUT ports, all inputs known from time zero
  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [COEF_W-1:0]    cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // [11:0] elem_index, [43:12] param_value, [75:44] grad_value, [79:76] zero
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [31:0] new_param, [63:32] decayed_grad
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // Predictor state: coefficient copies and velocity memory
  logic [COEF_W-1:0]        step_size  = LR_RESET;
  logic [COEF_W-1:0]        mom_coef   = '0;
  logic [COEF_W-1:0]        decay_coef = '0;
  logic signed [DATA_W-1:0] vel_mem [STORE_DEPTH];

  update_t   pending_updates[$];
  step_row_t directed_rows[$];

  int  fail_count     = 0;
  int  beats_in       = 0;
  int  beats_out      = 0;
  int  momentum_beats = 0;
  int  saturated_outs = 0;
  int  reg_writes     = 0;
  int  cycles         = 0;
  int  stall_left     = 0;
  bit  no_idle        = 1'b0;

  sgd_momentum_weight_decay_update DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Q16.16 predictor
  // ---------------------------------------------------------------------------

  function automatic logic signed [DATA_W-1:0] clamp32(longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[DATA_W-1:0];
  endfunction

  // Coefficient times value, scaled back with round half up (floor of p + half)
  function automatic longint mul_round(logic [COEF_W-1:0] c, logic signed [DATA_W-1:0] v);
    longint prod;
    prod = longint'(c) * longint'(v) + (longint'(1) <<< (FRAC_BITS - 1));
    return prod >>> FRAC_BITS;
  endfunction

  function automatic update_t predict_update(logic [IDX_W-1:0] idx,
                                             logic signed [DATA_W-1:0] param,
                                             logic signed [DATA_W-1:0] grad);
    update_t                  r;
    logic signed [DATA_W-1:0] g;
    logic signed [DATA_W-1:0] v;
    int unsigned              slot;
    slot = int'(idx) % STORE_DEPTH;
    g = clamp32(longint'(grad) + mul_round(decay_coef, param));
    if (mom_coef != '0) begin
      // Velocity is saturated before it is stored and before it scales the step
      v = clamp32(mul_round(mom_coef, vel_mem[slot]) + longint'(g));
      vel_mem[slot] = v;
      r.new_param = clamp32(longint'(param) - mul_round(step_size, v));
    end else begin
      // Momentum off: leave the velocity memory untouched
      r.new_param = clamp32(longint'(param) - mul_round(step_size, g));
    end
    r.decayed_grad = g;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random value shaping
  // ---------------------------------------------------------------------------

  // Mostly zero, sometimes a short gap, rarely a long one
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // Favor a few hot indexes so the velocity entries get reused, often back to back
  function automatic logic [IDX_W-1:0] rand_index();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return IDX_W'($urandom_range(0, 7));
    if (r < 9) return IDX_W'($urandom());
    return ($urandom_range(0, 1) != 0) ? '1 : '0;
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return DATA_W'($urandom_range(0, 1 << 20)) - 32'sd524288;
    if (r < 8) return DATA_W'($urandom());
    if (r < 9) return ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
    return DATA_W'($urandom_range(0, 1 << 25)) - 32'sd16777216;
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return C_MAX;
    if (r < 6) return COEF_W'($urandom_range(0, 8192));
    if (r < 8) return COEF_W'($urandom());
    return COEF_W'($urandom_range(60000, 70000));
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table builders
  // ---------------------------------------------------------------------------

  function automatic void add_write(logic [CFG_IDX_W-1:0] ri, logic [COEF_W-1:0] rv);
    step_row_t row;
    row         = '{kind: ROW_WRITE, default: '0};
    row.reg_idx = ri;
    row.reg_val = rv;
    directed_rows = {directed_rows, row};
  endfunction

  // typed = 1: the expected update is written into the row by hand
  function automatic void add_item(logic [IDX_W-1:0] idx, logic signed [DATA_W-1:0] p,
                                   logic signed [DATA_W-1:0] g, bit typed,
                                   logic signed [DATA_W-1:0] np,
                                   logic signed [DATA_W-1:0] dg);
    step_row_t row;
    row                   = '{kind: ROW_ITEM, default: '0};
    row.idx               = idx;
    row.param             = p;
    row.grad              = g;
    row.typed             = typed;
    row.want.new_param    = np;
    row.want.decayed_grad = dg;
    directed_rows = {directed_rows, row};
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus tasks
  // ---------------------------------------------------------------------------

  // Offer one beat; hold tvalid high across back-to-back beats, drop it in gaps
  task automatic push_beat(logic [IDX_W-1:0] idx, logic signed [DATA_W-1:0] p,
                           logic signed [DATA_W-1:0] g, bit typed, update_t want);
    int      gap;
    update_t pred;
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, g, p, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    // Beat accepted at this edge: advance the predictor
    if (mom_coef != '0) momentum_beats++;
    pred = predict_update(idx, p, g);
    pending_updates = {pending_updates, (typed ? want : pred)};
    beats_in++;
  endtask

  // Write a register only once the pipeline has drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] ri, logic [COEF_W-1:0] rv);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_updates.size() != 0);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= ri;
    cfg_wdata_i <= rv;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (ri)
      CFG_LEARNING_RATE: step_size  = rv;
      CFG_MOMENTUM:      mom_coef   = rv;
      CFG_WEIGHT_DECAY:  decay_coef = rv;
      default: ;
    endcase
    reg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure, then compare each beat
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : rx_pace
    int n;
    n = 0;
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      if (!no_idle && $urandom_range(0, 2) == 0) n = idle_len();
      if (n != 0) begin
        m_axis_tready <= 1'b0;
        stall_left    <= n - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : rx_check
    update_t exp_upd;
    update_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = update_t'({m_axis_tdata[31:0], m_axis_tdata[63:32]});
      beats_out++;
      if (got.new_param == Q_MAX || got.new_param == Q_MIN) saturated_outs++;
      if (pending_updates.size() == 0) begin
        $display("%0t: unexpected output beat %h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        exp_upd = pending_updates.pop_front();
        if (got.new_param !== exp_upd.new_param) begin
          $display("%0t: new_param expected %0d got %0d", $time,
                   exp_upd.new_param, got.new_param);
          fail_count++;
        end
        if (got.decayed_grad !== exp_upd.decayed_grad) begin
          $display("%0t: decayed_grad expected %0d got %0d", $time,
                   exp_upd.decayed_grad, got.decayed_grad);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: the slowest legal run is far below this
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d updates still pending", $time, pending_updates.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    foreach (vel_mem[i]) vel_mem[i] = '0;

    // Reset values: lr about 0.01, momentum and decay off
    add_item(12'd0,    32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd0);
    add_item(12'd4095, Q_MAX,  32'sd0, 1'b1, Q_MAX,  32'sd0);
    add_item(12'd1,    32'sd0, Q_ONE,  1'b1, -32'sd655, Q_ONE);
    add_item(12'd2,    Q_MIN,  Q_MIN,  1'b0, '0, '0);
    add_item(12'd3,    -32'sd1, -32'sd1, 1'b0, '0, '0);

    // Maximum decay with no step: decayed gradient saturates both ways
    add_write(CFG_LEARNING_RATE, '0);
    add_write(CFG_WEIGHT_DECAY, C_MAX);
    add_item(12'd10, Q_MAX, Q_MAX, 1'b1, Q_MAX, Q_MAX);
    add_item(12'd11, Q_MIN, Q_MIN, 1'b1, Q_MIN, Q_MIN);
    add_item(12'd12, Q_ONE, 32'sd0, 1'b0, '0, '0);

    // Maximum step, no decay: the parameter saturates both ways
    add_write(CFG_LEARNING_RATE, C_MAX);
    add_write(CFG_WEIGHT_DECAY, '0);
    add_item(12'd13, Q_MIN, Q_MAX, 1'b1, Q_MIN, Q_MAX);
    add_item(12'd14, Q_MAX, Q_MIN, 1'b1, Q_MAX, Q_MIN);

    // Unmapped register index: must not disturb the step size
    add_write(CFG_UNMAPPED, 18'h12345);
    add_item(12'd15, 32'sd0, Q_ONE, 1'b0, '0, '0);

    // Momentum on: same index back to back exercises the velocity loop
    add_write(CFG_LEARNING_RATE, 18'd655);
    add_write(CFG_WEIGHT_DECAY, 18'd6554);
    add_write(CFG_MOMENTUM, 18'd32768);
    repeat (4) add_item(12'd7, 3 * Q_ONE, Q_ONE, 1'b0, '0, '0);
    add_item(12'd4095, 32'sd123456, Q_MAX, 1'b0, '0, '0);
    add_item(12'd7, -32'sd99999, -Q_ONE, 1'b0, '0, '0);

    // Maximum momentum: velocity saturates
    add_write(CFG_MOMENTUM, C_MAX);
    add_item(12'd5, 32'sd0, Q_MAX, 1'b0, '0, '0);
    add_item(12'd5, 32'sd0, Q_MAX, 1'b0, '0, '0);
    add_item(12'd5, 32'sd0, Q_MIN, 1'b0, '0, '0);

    // Momentum off keeps the velocity; turning it back on reuses it
    add_write(CFG_MOMENTUM, '0);
    add_item(12'd5, Q_ONE, Q_ONE, 1'b0, '0, '0);
    add_write(CFG_MOMENTUM, 18'd65536);
    add_item(12'd5, Q_ONE, Q_ONE, 1'b0, '0, '0);
    add_item(12'd7, Q_ONE, Q_ONE, 1'b0, '0, '0);

    // Hold reset, then release it once
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        push_beat(directed_rows[i].idx, directed_rows[i].param, directed_rows[i].grad,
                  directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases, each with fresh coefficients; some run without idling
    for (int ph = 0; ph < PHASES; ph++) begin
      no_idle <= (ph % 3 == 1);
      write_reg(CFG_LEARNING_RATE, rand_coef());
      write_reg(CFG_MOMENTUM, (ph % 4 == 2) ? '0 : rand_coef());
      write_reg(CFG_WEIGHT_DECAY, rand_coef());
      if (ph % 2 == 1) write_reg(CFG_UNMAPPED, COEF_W'($urandom()));
      repeat (PHASE_BEATS) push_beat(rand_index(), rand_value(), rand_value(), 1'b0, '0);
    end

    // Drain, then let the pipeline settle to catch stray beats
    s_axis_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d input beats, %0d output beats, %0d register writes",
             beats_in, beats_out, reg_writes);
    $display("%0d beats with momentum on, %0d saturated parameters, %0d mismatches",
             momentum_beats, saturated_outs, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
